@@ design/pdr_pkg.sv @@
package pdr_pkg;

   localparam int PERIOD_W = 28;
   localparam int CLK_W    = 26;
   localparam int DEN_W    = 33;
   localparam int NUM_W    = 32;
   localparam int REM_W    = 37;
   localparam int FREQ_W   = 24;
   localparam int DNUM_W   = 36;
   localparam int DREM_W   = 29;
   localparam int SCALE_W  = 37;

   localparam int INT_BITS_DEF     = 8;
   localparam int FRAC_BITS_DEF    = 14;
   localparam int DIVISOR_BITS_DEF = 8;

   localparam int FREQ_STEPS  = 24;
   localparam int BASE_STEPS  = 32;
   localparam int DUTY_STEPS  = 36;
   localparam int DIGIT_CELLS = 5;
   localparam int DIGIT_START = FREQ_STEPS + BASE_STEPS;

   localparam logic [CLK_W-1:0]    CLK_RESET    = 26'd19200000;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 28'd104;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 28'd218453000;
   localparam logic [PERIOD_W-1:0] RANGE_SWITCH = 28'd13333;
   localparam logic [SCALE_W-1:0]  NS_LO        = 37'd1000000000;
   localparam logic [SCALE_W-1:0]  NS_HI        = 37'd100000000000;
   localparam logic [7:0]          CMP_MAX      = 8'd255;

   typedef enum logic [2:0] {
      STEP_FREQ,
      STEP_BASE,
      STEP_MUL10,
      STEP_DIGIT,
      STEP_BIN
   } pdr_step_type;

   typedef struct packed {
      logic valid;
      logic err;
      logic qnz;
   } pdr_ctl_type;

   function automatic int pdr_stage_count(input int frac);
      return DIGIT_START + (DIGIT_CELLS + 1) * frac;
   endfunction

   function automatic pdr_step_type pdr_step_kind(input int idx, input int frac);
      pdr_step_type k;
      if (idx < FREQ_STEPS) begin
         k = STEP_FREQ;
      end else if (idx < DIGIT_START) begin
         k = STEP_BASE;
      end else if (idx < DIGIT_START + DIGIT_CELLS * frac) begin
         k = ((idx - DIGIT_START) % DIGIT_CELLS == 0) ? STEP_MUL10 : STEP_DIGIT;
      end else begin
         k = STEP_BIN;
      end
      return k;
   endfunction

   function automatic int pdr_digit_sub(input int idx);
      int s;
      s = 0;
      if (idx >= DIGIT_START && (idx - DIGIT_START) % DIGIT_CELLS != 0) begin
         s = DIGIT_CELLS - 1 - (idx - DIGIT_START) % DIGIT_CELLS;
      end
      return s;
   endfunction

   function automatic logic [63:0] pdr_pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

@@ design/pdr_if.sv @@
interface pdr_req_if import pdr_pkg::*;;
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] pwm_period;
   logic [PERIOD_W-1:0] duty_ns;

   modport source (output valid, output pwm_period, output duty_ns, input ready);
   modport sink (input valid, input pwm_period, input duty_ns, output ready);
endinterface

interface pdr_rsp_if import pdr_pkg::*; #(
   parameter int INT_BITS     = INT_BITS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int DIVISOR_BITS = DIVISOR_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [INT_BITS-1:0]     base_int;
   logic [FRAC_BITS-1:0]    base_frac;
   logic [DIVISOR_BITS-1:0] on_time_div;
   logic                    range_error;

   modport source (output valid, output base_int, output base_frac, output on_time_div,
                   output range_error, input ready);
   modport sink (input valid, input base_int, input base_frac, input on_time_div,
                 input range_error, output ready);
endinterface

interface pdr_csr_if import pdr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CLK_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ design/pdr_cell.sv @@
module pdr_cell import pdr_pkg::*; #(
   parameter pdr_step_type KIND = STEP_FREQ,
   parameter int SUB           = 0,
   parameter bit LAST_FREQ     = 1'b0,
   parameter bit DUTY          = 1'b0,
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int DIVISOR_BITS  = DIVISOR_BITS_DEF,
   parameter int DEC_W         = 47
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  pdr_ctl_type             src_ctl,
   input  logic [PERIOD_W-1:0]     src_period,
   input  logic [DEN_W-1:0]        src_den,
   input  logic [NUM_W-1:0]        src_num,
   input  logic [REM_W-1:0]        src_rem,
   input  logic [FREQ_W-1:0]       src_quo,
   input  logic [DEC_W-1:0]        src_dec,
   input  logic [FRAC_BITS-1:0]    src_bits,
   input  logic [DNUM_W-1:0]       src_dnum,
   input  logic [DREM_W-1:0]       src_drem,
   input  logic [DIVISOR_BITS-1:0] src_dquo,
   output pdr_ctl_type             ctl_ff,
   output logic [PERIOD_W-1:0]     period_ff,
   output logic [DEN_W-1:0]        den_ff,
   output logic [NUM_W-1:0]        num_ff,
   output logic [REM_W-1:0]        rem_ff,
   output logic [FREQ_W-1:0]       quo_ff,
   output logic [DEC_W-1:0]        dec_ff,
   output logic [FRAC_BITS-1:0]    bits_ff,
   output logic [DNUM_W-1:0]       dnum_ff,
   output logic [DREM_W-1:0]       drem_ff,
   output logic [DIVISOR_BITS-1:0] dquo_ff
);

   localparam int DEC_W1  = DEC_W + 1;
   localparam int DREM_W1 = DREM_W + 1;

   pdr_ctl_type             ctl_in;
   logic [NUM_W-1:0]        num_in;
   logic [REM_W-1:0]        rem_in;
   logic [FREQ_W-1:0]       quo_in;
   logic [DEC_W-1:0]        dec_in;
   logic [FRAC_BITS-1:0]    bits_in;
   logic [DNUM_W-1:0]       dnum_in;
   logic [DREM_W-1:0]       drem_in;
   logic [DIVISOR_BITS-1:0] dquo_in;

   logic [REM_W-1:0]   shl;
   logic [REM_W-1:0]   dvs;
   logic [REM_W-1:0]   dsh;
   logic               ge;
   logic [DEC_W1-1:0]  d2;
   logic [DEC_W1-1:0]  scl;
   logic [DREM_W1-1:0] dt;
   logic [DREM_W1-1:0] dper;

   always_comb begin
      ctl_in  = src_ctl;
      num_in  = src_num;
      rem_in  = src_rem;
      quo_in  = src_quo;
      dec_in  = src_dec;
      bits_in = src_bits;
      shl     = {src_rem[REM_W-2:0], src_num[NUM_W-1]};
      dvs     = (KIND == STEP_FREQ) ? REM_W'(src_period) : REM_W'(src_den);
      dsh     = REM_W'(src_den) << SUB;
      ge      = 1'b0;
      d2      = {src_dec, 1'b0};
      scl     = DEC_W1'(pdr_pow10(FRAC_BITS));
      case (KIND)
         STEP_FREQ, STEP_BASE: begin
            ge     = (shl >= dvs);
            rem_in = ge ? (shl - dvs) : shl;
            quo_in = {src_quo[FREQ_W-2:0], ge};
            num_in = src_num << 1;
            if (KIND == STEP_BASE) begin
               ctl_in.qnz = src_ctl.qnz | ge;
            end
            if (LAST_FREQ) begin
               // The frequency is done: it becomes the next dividend, times 256.
               num_in = {quo_in, {(NUM_W - FREQ_W){1'b0}}};
               quo_in = '0;
               rem_in = '0;
            end
         end
         STEP_MUL10: begin
            rem_in = (src_rem << 3) + (src_rem << 1);
            dec_in = (src_dec << 3) + (src_dec << 1);
         end
         STEP_DIGIT: begin
            ge = (src_rem >= dsh);
            if (ge) begin
               rem_in = src_rem - dsh;
               dec_in = src_dec + (DEC_W'(1) << SUB);
            end
         end
         STEP_BIN: begin
            ge      = (d2 >= scl);
            dec_in  = ge ? DEC_W'(d2 - scl) : DEC_W'(d2);
            bits_in = {src_bits[FRAC_BITS-2:0], ge};
         end
         default: ;
      endcase
   end

   always_comb begin
      dt   = {src_drem, src_dnum[DNUM_W-1]};
      dper = DREM_W1'(src_period);
      if (DUTY) begin
         dnum_in = src_dnum << 1;
         if (dt >= dper) begin
            drem_in = DREM_W'(dt - dper);
            dquo_in = {src_dquo[DIVISOR_BITS-2:0], 1'b1};
         end else begin
            drem_in = DREM_W'(dt);
            dquo_in = {src_dquo[DIVISOR_BITS-2:0], 1'b0};
         end
      end else begin
         dnum_in = src_dnum;
         drem_in = src_drem;
         dquo_in = src_dquo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         period_ff <= src_period;
         den_ff    <= src_den;
         num_ff    <= num_in;
         rem_ff    <= rem_in;
         quo_ff    <= quo_in;
         dec_ff    <= dec_in;
         bits_ff   <= bits_in;
         dnum_ff   <= dnum_in;
         drem_ff   <= drem_in;
         dquo_ff   <= dquo_in;
      end
   end

endmodule

@@ design/pwm_period_duty_to_register_fields_top.sv @@
// Converts a PWM period and high time in nanoseconds into the base-unit integer, the binary
// base-unit fraction and the on-time divisor for a counter run at the clock rate held in the
// one configuration register. A request is taken every cycle unless the output buffer is full;
// each passes through a row of one-bit divider cells: 24 for the frequency, 32 for the base
// unit, five per decimal fraction digit and one per binary fraction bit, the duty quotient
// running alongside the first 36. A two-entry output buffer lets the row keep moving while
// one result waits to be taken.
module pwm_period_duty_to_register_fields_top import pdr_pkg::*; #(
   parameter int INT_BITS     = INT_BITS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int DIVISOR_BITS = DIVISOR_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   pdr_req_if.sink      req_ch,
   pdr_rsp_if.source    rsp_ch,
   pdr_csr_if.sink      csr_ch
);

   localparam int NSTAGE = pdr_stage_count(FRAC_BITS);
   localparam int DEC_W  = $clog2(pdr_pow10(FRAC_BITS));

   typedef struct packed {
      logic [INT_BITS-1:0]     base_int;
      logic [FRAC_BITS-1:0]    base_frac;
      logic [DIVISOR_BITS-1:0] on_time_div;
      logic                    range_error;
   } res_type;

   logic [CLK_W-1:0] clk_ff;
   logic [CLK_W-1:0] clk_eff;
   logic             dr;
   logic [DEN_W-1:0] den_c;
   logic [SCALE_W-1:0] nsrc;
   logic             en;

   pdr_ctl_type             ctl   [0:NSTAGE];
   logic [PERIOD_W-1:0]     per   [0:NSTAGE];
   logic [DEN_W-1:0]        den   [0:NSTAGE];
   logic [NUM_W-1:0]        num   [0:NSTAGE];
   logic [REM_W-1:0]        rem   [0:NSTAGE];
   logic [FREQ_W-1:0]       quo   [0:NSTAGE];
   logic [DEC_W-1:0]        dec   [0:NSTAGE];
   logic [FRAC_BITS-1:0]    fbits [0:NSTAGE];
   logic [DNUM_W-1:0]       dnum  [0:NSTAGE];
   logic [DREM_W-1:0]       drem  [0:NSTAGE];
   logic [DIVISOR_BITS-1:0] dquo  [0:NSTAGE];

   res_type res_c;
   res_type out_ff;
   res_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff <= CLK_RESET;
      end else if (csr_ch.valid) begin
         clk_ff <= csr_ch.data;
      end
   end

   // The row only stops when the output buffer holds two results.
   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   always_comb begin
      clk_eff = (clk_ff == '0) ? CLK_W'(1) : clk_ff;
      dr      = (req_ch.pwm_period >= RANGE_SWITCH);
      den_c   = dr ? ((DEN_W'(clk_eff) << 6) + (DEN_W'(clk_eff) << 5) + (DEN_W'(clk_eff) << 2))
                   : DEN_W'(clk_eff);
      nsrc    = dr ? NS_HI : NS_LO;

      ctl[0].valid = req_ch.valid && en;
      ctl[0].err   = (req_ch.pwm_period < PERIOD_MIN) || (req_ch.pwm_period > PERIOD_MAX);
      ctl[0].qnz   = 1'b0;
      per[0]   = req_ch.pwm_period;
      den[0]   = den_c;
      // The frequency quotient is known to fit in FREQ_W bits, so the top of the
      // dividend starts out as the partial remainder.
      rem[0]   = REM_W'(nsrc >> FREQ_STEPS);
      num[0]   = {nsrc[FREQ_STEPS-1:0], {(NUM_W - FREQ_STEPS){1'b0}}};
      quo[0]   = '0;
      dec[0]   = '0;
      fbits[0] = '0;
      dnum[0]  = (DNUM_W'(req_ch.duty_ns) << 8) - DNUM_W'(req_ch.duty_ns);
      drem[0]  = '0;
      dquo[0]  = '0;
   end

   for (genvar s = 0; s < NSTAGE; s++) begin : g_cell
      pdr_cell #(
         .KIND         (pdr_step_kind(s, FRAC_BITS)),
         .SUB          (pdr_digit_sub(s)),
         .LAST_FREQ    (s == FREQ_STEPS - 1),
         .DUTY         (s < DUTY_STEPS),
         .FRAC_BITS    (FRAC_BITS),
         .DIVISOR_BITS (DIVISOR_BITS),
         .DEC_W        (DEC_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .src_ctl    (ctl[s]),
         .src_period (per[s]),
         .src_den    (den[s]),
         .src_num    (num[s]),
         .src_rem    (rem[s]),
         .src_quo    (quo[s]),
         .src_dec    (dec[s]),
         .src_bits   (fbits[s]),
         .src_dnum   (dnum[s]),
         .src_drem   (drem[s]),
         .src_dquo   (dquo[s]),
         .ctl_ff     (ctl[s+1]),
         .period_ff  (per[s+1]),
         .den_ff     (den[s+1]),
         .num_ff     (num[s+1]),
         .rem_ff     (rem[s+1]),
         .quo_ff     (quo[s+1]),
         .dec_ff     (dec[s+1]),
         .bits_ff    (fbits[s+1]),
         .dnum_ff    (dnum[s+1]),
         .drem_ff    (drem[s+1]),
         .dquo_ff    (dquo[s+1])
      );
   end

   always_comb begin
      res_c.range_error = ctl[NSTAGE].err;
      if (ctl[NSTAGE].err) begin
         res_c.base_int    = '0;
         res_c.base_frac   = '0;
         res_c.on_time_div = '0;
      end else begin
         res_c.base_int = INT_BITS'(quo[NSTAGE]);
         // A base unit that would be zero altogether is raised to the smallest fraction.
         res_c.base_frac = (fbits[NSTAGE] == '0 && !ctl[NSTAGE].qnz) ? FRAC_BITS'(1)
                                                                      : fbits[NSTAGE];
         res_c.on_time_div = DIVISOR_BITS'(CMP_MAX) - dquo[NSTAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !rsp_ch.ready) begin
         if (en && ctl[NSTAGE].valid) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= en && ctl[NSTAGE].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp_ch.ready) begin
         if (en && ctl[NSTAGE].valid) begin
            skid_ff <= res_c;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= res_c;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.base_int    = out_ff.base_int;
   assign rsp_ch.base_frac   = out_ff.base_frac;
   assign rsp_ch.on_time_div = out_ff.on_time_div;
   assign rsp_ch.range_error = out_ff.range_error;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("second output entry held without a first");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ch.ready))
      else $error("second output entry filled while the first was free");

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.range_error |->
         rsp_ch.base_int == '0 && rsp_ch.base_frac == '0 && rsp_ch.on_time_div == '0)
      else $error("range error result carries nonzero fields");
`endif

endmodule

@@ tb/sv/pwm_period_duty_to_register_fields_top_tb.sv @@
module pwm_period_duty_to_register_fields_top_tb import pdr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAP_MAX     = 13;
   localparam int DRAIN_WAIT  = 200;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [7:0]  base_int;
      logic [13:0] base_frac;
      logic [7:0]  on_time_div;
      logic        range_error;
   } pwm_fields_type;

   logic clock;
   logic reset;

   pdr_req_if req_ch();
   pdr_rsp_if rsp_ch();
   pdr_csr_if csr_ch();

   pwm_period_duty_to_register_fields_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pwm_fields_type    pending_fields[$];
   logic [CLK_W-1:0] clock_hz_copy;
   int             error_count;
   int             mismatch_count;
   int             idle_cycles;
   int             hold_len;
   bit             steady_flow;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Bit-exact conversion of one period and duty pair at the given clock rate.
   function automatic pwm_fields_type convert_period(input logic [27:0] period,
                                                     input logic [27:0] duty,
                                                     input logic [CLK_W-1:0] clk_reg);
      pwm_fields_type f;
      longint unsigned clk_hz, scale_dr, den, freq, q, rem, dec, pow, frac, t, quot;
      f = '0;
      if (period < 28'd104 || period > 28'd218453000) begin
         f.range_error = 1'b1;
         return f;
      end
      clk_hz = (clk_reg == 0) ? 64'd1 : 64'(clk_reg);
      scale_dr = (period < 28'd13333) ? 64'd1 : 64'd100;
      den = clk_hz * scale_dr;
      freq = (64'd1000000000 * scale_dr) / 64'(period);
      q = (freq * 64'd256) / den;
      rem = (freq * 64'd256) % den;
      dec = 0;
      pow = 1;
      for (int i = 0; i < 14; i++) begin
         t = rem * 64'd10;
         dec = dec * 64'd10 + t / den;
         rem = t % den;
         pow = pow * 64'd10;
      end
      frac = 0;
      for (int i = 0; i < 14; i++) begin
         dec = dec << 1;
         frac = frac << 1;
         if (dec >= pow) begin
            frac = frac | 64'd1;
            dec = dec - pow;
         end
      end
      if (frac == 0 && q == 0) begin
         frac = 1;
      end
      quot = (64'(duty) * 64'd255) / 64'(period);
      f.base_int = q[7:0];
      f.base_frac = frac[13:0];
      f.on_time_div = 8'(64'd255 - quot);
      return f;
   endfunction

   // Sends one request; valid stays high across back-to-back requests.
   task automatic send_request(input logic [27:0] period, input logic [27:0] duty);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pwm_period <= period;
      req_ch.duty_ns <= duty;
      do @(posedge clock); while (!req_ch.ready);
      pending_fields.push_back(convert_period(period, duty, clock_hz_copy));
   endtask

   task automatic stop_requests();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_clock_rate(input logic [CLK_W-1:0] rate);
      stop_requests();
      wait (pending_fields.size() == 0);
      // Every accepted request has its result by now, so the divider row holds no request.
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= rate;
      do @(posedge clock); while (!csr_ch.ready);
      clock_hz_copy = rate;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_random_request();
      logic [27:0] period;
      logic [27:0] duty;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         period = 28'($urandom_range(104, 13332));
      end else if (pick < 6) begin
         period = 28'($urandom_range(13333, 218453000));
      end else if (pick < 8) begin
         period = 28'($urandom_range(0, 28'hFFFFFFF));
      end else begin
         period = 28'($urandom_range(0, 200));
      end
      if ($urandom_range(0, 4) == 0) begin
         duty = 28'($urandom_range(0, 28'hFFFFFFF));
      end else begin
         duty = 28'($urandom_range(0, period));
      end
      send_request(period, duty);
   endtask

   task automatic test_directed();
      send_request(28'd0, 28'd0);
      send_request(28'd103, 28'd50);
      send_request(28'd104, 28'd0);
      send_request(28'd104, 28'd104);
      send_request(28'd105, 28'd200);
      send_request(28'd13332, 28'd6666);
      send_request(28'd13333, 28'd13333);
      send_request(28'd13334, 28'd1);
      send_request(28'd218453000, 28'd218453000);
      send_request(28'd218453001, 28'd5);
      send_request(28'hFFFFFFF, 28'hFFFFFFF);
      send_request(28'd1000000, 28'hFFFFFFF);
      send_request(28'd20000, 28'd0);
      send_request(28'd50000, 28'd49999);
   endtask

   task automatic test_clock_settings();
      logic [CLK_W-1:0] rates[7];
      rates = '{26'd1000000, 26'd40000000, 26'd0, 26'h3FFFFFF, 26'd1, 26'h2AAAAAA,
                26'h1555555};
      foreach (rates[i]) begin
         write_clock_rate(rates[i]);
         // Slow periods at a fast clock give a base unit that would be zero, raised to the smallest fraction.
         send_request(28'd218453000, 28'd1000);
         send_request(28'd104, 28'd52);
         send_request(28'd13333, 28'd0);
         repeat (12) send_random_request();
      end
      write_clock_rate(26'd19200000);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 300 == 0 && i > 0) begin
            write_clock_rate(CLK_W'($urandom_range(0, 26'h3FFFFFF)));
         end
         steady_flow = ((i / 100) % 4 == 3);
         send_random_request();
      end
      steady_flow = 1'b0;
   endtask

   // Enough back-to-back requests to fill the whole divider row while the receiver holds off.
   task automatic test_backpressure();
      hold_len = HOLD_CYCLES;
      steady_flow = 1'b1;
      repeat (200) send_random_request();
      steady_flow = 1'b0;
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_len > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         if (!steady_flow) begin
            int gap;
            gap = $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_fields.size() == 0) begin
            error_count++;
            $display("Unexpected result at %0t", $realtime);
         end else begin
            pwm_fields_type exp_f;
            pwm_fields_type got_f;
            exp_f = pending_fields.pop_front();
            got_f = {rsp_ch.base_int, rsp_ch.base_frac, rsp_ch.on_time_div,
                     rsp_ch.range_error};
            if (got_f !== exp_f) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch at %0t: expected int %0d frac %0d div %0d err %0b",
                           $realtime, exp_f.base_int, exp_f.base_frac,
                           exp_f.on_time_div, exp_f.range_error);
                  $display("   actual int %0d frac %0d div %0d err %0b", got_f.base_int,
                           got_f.base_frac, got_f.on_time_div, got_f.range_error);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pwm_period = '0;
      req_ch.duty_ns = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      clock_hz_copy = CLK_RESET;
      error_count = 0;
      mismatch_count = 0;
      idle_cycles = 0;
      hold_len = 0;
      steady_flow = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_clock_settings();
      test_backpressure();
      test_random(1400);
      stop_requests();
      wait (pending_fields.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && pending_fields.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
